[hw/rtl/fpa_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the signed fixed-point ALU.
// Used by every module under hw/rtl except fpa_checker; depends on nothing else.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  // shifted dividend width, one divider cell per quotient bit
  localparam int DIV_W     = DATA_W + FRAC_BITS;

  typedef enum logic [3:0] {
    FN_ADD  = 4'd0,
    FN_SUB  = 4'd1,
    FN_MUL  = 4'd2,
    FN_DIV  = 4'd3,
    FN_GT   = 4'd4,
    FN_LT   = 4'd5,
    FN_GE   = 4'd6,
    FN_LE   = 4'd7,
    FN_EQ   = 4'd8,
    FN_NE   = 4'd9,
    FN_MIN  = 4'd10,
    FN_MAX  = 4'd11,
    FN_INC  = 4'd12,
    FN_DEC  = 4'd13,
    FN_I2F  = 4'd14,
    FN_F2I  = 4'd15
  } func_t;

  // one pipeline slot as it moves down the chain
  typedef struct packed {
    logic               vld;
    func_t              func;
    logic [DATA_W-1:0]  val;   // finished result for everything but divide
    logic               cmp;
    logic               dz;
    logic               neg;   // quotient sign
    logic [DATA_W-1:0]  rem;   // partial remainder
    logic [DIV_W-1:0]   quo;   // dividend bits shifting out, quotient bits in
    logic [DATA_W-1:0]  dvs;   // divisor magnitude
  } lane_t;

endpackage

[hw/rtl/fixed_point_alu_core.sv]
`timescale 1ns / 1ps
// Top level of the signed Q24.8 fixed-point ALU.
// Instantiates fpa_front, a chain of fpa_div_cell and fpa_back; uses fpa_pkg.
//
//  channel   direction  tdata                          tuser
//  in_       slave      [31:0] operand_a [63:32] b     [3:0] func
//  out_      master     [31:0] result_value            [0] compare_true [1] div_zero
//
// One transaction enters per cycle while the output is not stalled. It passes
// two front stages, one divider cell per quotient bit (DIV_W cells) and one
// output register. The divider chain sets the latency for every operation.
// Synchronous active-low reset empties the chain. A stalled output holds the
// whole chain and drops in_tready in the same cycle.
module fixed_point_alu_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] operand_a, [63:32] operand_b
  input  logic [3:0]  in_tuser,   // [3:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [1:0]  out_tuser   // [0] compare_true, [1] div_zero
);

  fpa_pkg::lane_t chain [0:fpa_pkg::DIV_W];
  logic           adv;

  fpa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_tvalid),
    .in_func (in_tuser),
    .in_a    (in_tdata[31:0]),
    .in_b    (in_tdata[63:32]),
    .lane_o  (chain[0])
  );

  for (genvar i = 0; i < fpa_pkg::DIV_W; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .lane_i (chain[i]),
      .lane_o (chain[i+1])
    );
  end

  fpa_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .lane_i  (chain[fpa_pkg::DIV_W]),
    .out_rdy (out_tready),
    .adv     (adv),
    .out_vld (out_tvalid),
    .out_val (out_tdata),
    .out_cmp (out_tuser[0]),
    .out_dz  (out_tuser[1])
  );

  assign in_tready = adv;

endmodule

[hw/rtl/fpa_front.sv]
`timescale 1ns / 1ps
// Front end: operand decode, simple operations, multiplier and divider setup.
// Two register stages; depends on fpa_pkg.
module fpa_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [3:0]                  in_func,
  input  logic [fpa_pkg::DATA_W-1:0]  in_a,
  input  logic [fpa_pkg::DATA_W-1:0]  in_b,
  output fpa_pkg::lane_t              lane_o
);

  fpa_pkg::lane_t                    s1_r, s1_nxt;
  fpa_pkg::lane_t                    s2_r, s2_nxt;
  logic signed [2*fpa_pkg::DATA_W-1:0] prod_r, prod_nxt;
  logic signed [2*fpa_pkg::DATA_W-1:0] prod_sh;
  logic signed [fpa_pkg::DATA_W-1:0]   sa, sb, f2i;
  logic [fpa_pkg::DATA_W-1:0]          a_mag, b_mag;

  always_comb begin
    sa       = $signed(in_a);
    sb       = $signed(in_b);
    f2i      = sa >>> fpa_pkg::FRAC_BITS;
    a_mag    = in_a[fpa_pkg::DATA_W-1] ? (fpa_pkg::DATA_W'(0) - in_a) : in_a;
    b_mag    = in_b[fpa_pkg::DATA_W-1] ? (fpa_pkg::DATA_W'(0) - in_b) : in_b;
    prod_nxt = sa * sb;

    s1_nxt      = '0;
    s1_nxt.vld  = in_vld;
    s1_nxt.func = fpa_pkg::func_t'(in_func);
    s1_nxt.neg  = in_a[fpa_pkg::DATA_W-1] ^ in_b[fpa_pkg::DATA_W-1];
    s1_nxt.rem  = '0;
    s1_nxt.quo  = {a_mag, {fpa_pkg::FRAC_BITS{1'b0}}};
    s1_nxt.dvs  = b_mag;
    case (fpa_pkg::func_t'(in_func))
      fpa_pkg::FN_ADD: s1_nxt.val = in_a + in_b;
      fpa_pkg::FN_SUB: s1_nxt.val = in_a - in_b;
      fpa_pkg::FN_DIV: s1_nxt.dz  = (in_b == '0);
      fpa_pkg::FN_GT:  s1_nxt.cmp = (sa > sb);
      fpa_pkg::FN_LT:  s1_nxt.cmp = (sa < sb);
      fpa_pkg::FN_GE:  s1_nxt.cmp = (sa >= sb);
      fpa_pkg::FN_LE:  s1_nxt.cmp = (sa <= sb);
      fpa_pkg::FN_EQ:  s1_nxt.cmp = (in_a == in_b);
      fpa_pkg::FN_NE:  s1_nxt.cmp = (in_a != in_b);
      fpa_pkg::FN_MIN: s1_nxt.val = (sa < sb) ? in_a : in_b;
      fpa_pkg::FN_MAX: s1_nxt.val = (sa > sb) ? in_a : in_b;
      fpa_pkg::FN_INC: s1_nxt.val = in_a + fpa_pkg::DATA_W'(1);
      fpa_pkg::FN_DEC: s1_nxt.val = in_a - fpa_pkg::DATA_W'(1);
      fpa_pkg::FN_I2F: s1_nxt.val = in_a << fpa_pkg::FRAC_BITS;
      fpa_pkg::FN_F2I: s1_nxt.val = f2i;
      default:         s1_nxt.val = '0;
    endcase
  end

  // second stage: scale the registered product back to Q format
  always_comb begin
    prod_sh = prod_r >>> fpa_pkg::FRAC_BITS;
    s2_nxt  = s1_r;
    if (s1_r.func == fpa_pkg::FN_MUL) begin
      s2_nxt.val = prod_sh[fpa_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else if (adv) begin
      s1_r   <= s1_nxt;
      prod_r <= prod_nxt;
      s2_r   <= s2_nxt;
    end
  end

  assign lane_o = s2_r;

endmodule

[hw/rtl/fpa_div_cell.sv]
`timescale 1ns / 1ps
// One restoring-division cell: settles one quotient bit per slot and passes it on.
// Depends on fpa_pkg.
module fpa_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  fpa_pkg::lane_t lane_i,
  output fpa_pkg::lane_t lane_o
);

  fpa_pkg::lane_t           lane_r, lane_nxt;
  logic [fpa_pkg::DATA_W:0] trial, diff;
  logic                     take;

  always_comb begin
    trial    = {lane_i.rem, lane_i.quo[fpa_pkg::DIV_W-1]};
    diff     = trial - {1'b0, lane_i.dvs};
    take     = (trial >= {1'b0, lane_i.dvs});
    lane_nxt = lane_i;
    lane_nxt.rem = take ? diff[fpa_pkg::DATA_W-1:0] : trial[fpa_pkg::DATA_W-1:0];
    lane_nxt.quo = {lane_i.quo[fpa_pkg::DIV_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else if (adv) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_o = lane_r;

endmodule

[hw/rtl/fpa_back.sv]
`timescale 1ns / 1ps
// Back end: quotient sign fix, result select and the output register.
// Produces the chain-wide advance; depends on fpa_pkg.
module fpa_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fpa_pkg::lane_t              lane_i,
  input  logic                        out_rdy,
  output logic                        adv,
  output logic                        out_vld,
  output logic [fpa_pkg::DATA_W-1:0]  out_val,
  output logic                        out_cmp,
  output logic                        out_dz
);

  logic                       vld_r;
  logic [fpa_pkg::DATA_W-1:0] val_r, val_nxt, q_lo;

  always_comb begin
    q_lo = lane_i.quo[fpa_pkg::DATA_W-1:0];
    if (lane_i.func == fpa_pkg::FN_DIV) begin
      if (lane_i.dz) begin
        val_nxt = '0;
      end else begin
        val_nxt = lane_i.neg ? (fpa_pkg::DATA_W'(0) - q_lo) : q_lo;
      end
    end else begin
      val_nxt = lane_i.val;
    end
  end

  // advance whenever the output slot is empty or being drained
  assign adv = !vld_r || out_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r   <= lane_i.vld;
      val_r   <= val_nxt;
      out_cmp <= lane_i.cmp;
      out_dz  <= lane_i.dz;
    end
  end

  assign out_vld = vld_r;
  assign out_val = val_r;

endmodule

[hw/rtl/fpa_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for fixed_point_alu_core, attached by bind.
// Depends only on the top level's ports.
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output slot");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == 32'd0 && !out_tuser[0])
    else $error("divide by zero result not cleared");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("compare result carries a value");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
